[hw/rtl/qete_pkg.sv]
// ----------------------------------------------------------------------------
// Quad-edge topology engine package
// Shared constants, sequencer state type, opcodes and edge rotation helper.
// ----------------------------------------------------------------------------
package qete_pkg;

    localparam int QuadEdges   = 256;
    localparam int QuadBits    = 8;
    localparam int EdgeBits    = QuadBits + 2;
    localparam int VertexBits  = 16;

    typedef logic [EdgeBits-1:0]   edge_t;
    typedef logic [VertexBits-1:0] vertex_t;

    typedef enum logic [2:0] {
        OP_MAKE    = 3'd0,
        OP_SPLICE  = 3'd1,
        OP_CONNECT = 3'd2,
        OP_DELETE  = 3'd3,
        OP_SWAP    = 3'd4,
        OP_QUERY   = 3'd5
    } opcode_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_ALLOC, ST_AL_POP,
        ST_IN_0, ST_IN_1, ST_IN_2, ST_IN_3,
        ST_CN_1, ST_CN_2, ST_CN_3, ST_CN_4, ST_CN_5,
        ST_DL_1, ST_DL_2, ST_DL_3, ST_DL_4, ST_DL_5,
        ST_SW_1, ST_SW_2, ST_SW_3, ST_SW_4, ST_SW_5, ST_SW_6,
        ST_SW_7, ST_SW_8, ST_SW_9, ST_SW_10, ST_SW_11, ST_SW_12,
        ST_SP_RA, ST_SP_RB, ST_SP_WA, ST_SP_WB,
        ST_SP_RAL, ST_SP_RBE, ST_SP_WAL, ST_SP_WBE,
        ST_OUT_R, ST_OUT_S, ST_OUT_D
    } state_t;

    // Rotate an edge reference by k quarter turns within its quad.
    function automatic edge_t edge_turn(input edge_t e, input logic [1:0] k);
        edge_turn = {e[EdgeBits-1:2], e[1:0] + k};
    endfunction

endpackage

[hw/rtl/quad_edge_topology_engine_unit.sv]
// ----------------------------------------------------------------------------
// Quad-edge topology engine
// Pool of quad-edges with make, splice, connect, delete, swap and query.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_ready  | opcode, edge_a, edge_b, org_vertex, dst_vertex
//  output  | out_valid/ out_ready | result_edge, onext_edge, origin_id, dest_id,
//          |                      | status
//
// One request is worked on at a time by a small sequencer that drives the single
// read and single write port of the ring memory and of the vertex memory. Every
// splice is a subroutine of four reads and four writes on the ring port. A make or
// connect that reuses a freed quad passes through an extra pop step.
// Reset leaves the memories untouched and clears the sequencer state, the
// output valid and error flags, the free-stack top and the fresh-quad counter,
// so the block is ready to take a request as soon as reset is released.
// A finished result waits in the output register while the next request is
// already accepted; the sequencer holds in its last step while that register
// is still occupied.
module quad_edge_topology_engine_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [9:0]  edge_a,
    input  logic [9:0]  edge_b,
    input  logic [15:0] org_vertex,
    input  logic [15:0] dst_vertex,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  result_edge,
    output logic [9:0]  onext_edge,
    output logic [15:0] origin_id,
    output logic [15:0] dest_id,
    output logic        status
);

    localparam int Records = 4 * qete_pkg::QuadEdges;

    // Memories: onext ring, vertex ids, free quad stack.
    qete_pkg::edge_t   ring_mem [Records];
    qete_pkg::vertex_t vs_mem   [Records];
    logic [qete_pkg::QuadBits-1:0] fs_mem [qete_pkg::QuadEdges];

    logic                ring_we;
    qete_pkg::edge_t     ring_waddr, ring_wdata, ring_raddr, ring_q;
    logic                vs_we;
    qete_pkg::edge_t     vs_waddr, vs_raddr;
    qete_pkg::vertex_t   vs_wdata, vs_q;
    logic                fs_we;
    logic [qete_pkg::QuadBits-1:0] fs_waddr, fs_wdata, fs_raddr, fs_q;

    qete_pkg::state_t  state_reg, state_next, ret_reg, ret_next;
    logic [2:0]        op_reg, op_next;
    qete_pkg::edge_t   a_reg, a_next, b_reg, b_next, e_reg, e_next;
    qete_pkg::edge_t   x_reg, x_next, y_reg, y_next;
    qete_pkg::edge_t   sa_reg, sa_next, sb_reg, sb_next;
    qete_pkg::edge_t   ta_reg, ta_next, tb_reg, tb_next, u_reg, u_next;
    qete_pkg::edge_t   on_reg, on_next;
    qete_pkg::vertex_t org_reg, org_next, dst_reg, dst_next;
    qete_pkg::vertex_t xv_reg, xv_next, yv_reg, yv_next, ori_reg, ori_next;
    logic              err_reg, err_next;
    logic [qete_pkg::QuadBits:0] free_top_reg, free_top_next, fresh_reg, fresh_next;
    logic              out_valid_reg, out_valid_next;
    qete_pkg::edge_t   res_reg, res_next, onx_out_reg, onx_out_next;
    qete_pkg::vertex_t org_out_reg, org_out_next, dst_out_reg, dst_out_next;
    logic              status_reg, status_next;
    qete_pkg::edge_t   r_sel;

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        ring_q <= ring_mem[ring_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vs_we)
        begin
            vs_mem[vs_waddr] <= vs_wdata;
        end
        vs_q <= vs_mem[vs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            fs_mem[fs_waddr] <= fs_wdata;
        end
        fs_q <= fs_mem[fs_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qete_pkg::ST_IDLE;
            ret_reg       <= qete_pkg::ST_IDLE;
            free_top_reg  <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            free_top_reg  <= free_top_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        e_reg       <= e_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        ta_reg      <= ta_next;
        tb_reg      <= tb_next;
        u_reg       <= u_next;
        on_reg      <= on_next;
        org_reg     <= org_next;
        dst_reg     <= dst_next;
        xv_reg      <= xv_next;
        yv_reg      <= yv_next;
        ori_reg     <= ori_next;
        res_reg     <= res_next;
        onx_out_reg <= onx_out_next;
        org_out_reg <= org_out_next;
        dst_out_reg <= dst_out_next;
        status_reg  <= status_next;
    end

    // The result edge is the new edge for make and connect, else edge_a.
    assign r_sel = (op_reg == qete_pkg::OP_MAKE || op_reg == qete_pkg::OP_CONNECT)
                   ? e_reg : a_reg;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        e_next         = e_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        u_next         = u_reg;
        on_next        = on_reg;
        org_next       = org_reg;
        dst_next       = dst_reg;
        xv_next        = xv_reg;
        yv_next        = yv_reg;
        ori_next       = ori_reg;
        err_next       = err_reg;
        free_top_next  = free_top_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        onx_out_next   = onx_out_reg;
        org_out_next   = org_out_reg;
        dst_out_next   = dst_out_reg;
        status_next    = status_reg;
        in_ready       = 1'b0;
        ring_we        = 1'b0;
        ring_waddr     = e_reg;
        ring_wdata     = e_reg;
        ring_raddr     = a_reg;
        vs_we          = 1'b0;
        vs_waddr       = e_reg;
        vs_wdata       = '0;
        vs_raddr       = a_reg;
        fs_we          = 1'b0;
        fs_waddr       = free_top_reg[qete_pkg::QuadBits-1:0];
        fs_wdata       = a_reg[qete_pkg::EdgeBits-1:2];
        fs_raddr       = fs_waddr;

        case (state_reg)
            qete_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next  = opcode;
                    a_next   = edge_a;
                    b_next   = edge_b;
                    org_next = org_vertex;
                    dst_next = dst_vertex;
                    err_next = 1'b0;
                    case (opcode)
                        qete_pkg::OP_MAKE, qete_pkg::OP_CONNECT:
                        begin
                            state_next = qete_pkg::ST_ALLOC;
                        end
                        qete_pkg::OP_SPLICE:
                        begin
                            sa_next    = edge_a;
                            sb_next    = edge_b;
                            ret_next   = qete_pkg::ST_OUT_R;
                            state_next = qete_pkg::ST_SP_RA;
                        end
                        qete_pkg::OP_DELETE: state_next = qete_pkg::ST_DL_1;
                        qete_pkg::OP_SWAP:   state_next = qete_pkg::ST_SW_1;
                        default:             state_next = qete_pkg::ST_OUT_R;
                    endcase
                end
            end

            // Allocation: freed quads first, then fresh ones.
            qete_pkg::ST_ALLOC:
            begin
                if (free_top_reg != '0)
                begin
                    free_top_next = free_top_reg - 1'b1;
                    fs_raddr      = free_top_next[qete_pkg::QuadBits-1:0];
                    state_next    = qete_pkg::ST_AL_POP;
                end
                else if (!fresh_reg[qete_pkg::QuadBits])
                begin
                    e_next     = {fresh_reg[qete_pkg::QuadBits-1:0], 2'b00};
                    fresh_next = fresh_reg + 1'b1;
                    state_next = qete_pkg::ST_IN_0;
                end
                else
                begin
                    err_next   = 1'b1;
                    state_next = qete_pkg::ST_OUT_D;
                end
            end
            qete_pkg::ST_AL_POP:
            begin
                e_next     = {fs_q, 2'b00};
                state_next = qete_pkg::ST_IN_0;
            end

            // Isolated edge setup.
            qete_pkg::ST_IN_0:
            begin
                ring_we    = 1'b1;
                ring_waddr = e_reg;
                ring_wdata = e_reg;
                vs_we      = 1'b1;
                vs_waddr   = qete_pkg::edge_turn(e_reg, 2'd1);
                state_next = qete_pkg::ST_IN_1;
            end
            qete_pkg::ST_IN_1:
            begin
                ring_we    = 1'b1;
                ring_waddr = qete_pkg::edge_turn(e_reg, 2'd1);
                ring_wdata = qete_pkg::edge_turn(e_reg, 2'd3);
                vs_we      = 1'b1;
                vs_waddr   = qete_pkg::edge_turn(e_reg, 2'd3);
                state_next = qete_pkg::ST_IN_2;
            end
            qete_pkg::ST_IN_2:
            begin
                ring_we    = 1'b1;
                ring_waddr = qete_pkg::edge_turn(e_reg, 2'd2);
                ring_wdata = qete_pkg::edge_turn(e_reg, 2'd2);
                vs_we      = (op_reg == qete_pkg::OP_MAKE);
                vs_waddr   = e_reg;
                vs_wdata   = org_reg;
                state_next = qete_pkg::ST_IN_3;
            end
            qete_pkg::ST_IN_3:
            begin
                ring_we    = 1'b1;
                ring_waddr = qete_pkg::edge_turn(e_reg, 2'd3);
                ring_wdata = qete_pkg::edge_turn(e_reg, 2'd1);
                if (op_reg == qete_pkg::OP_MAKE)
                begin
                    vs_we      = 1'b1;
                    vs_waddr   = qete_pkg::edge_turn(e_reg, 2'd2);
                    vs_wdata   = dst_reg;
                    state_next = qete_pkg::ST_OUT_R;
                end
                else
                begin
                    state_next = qete_pkg::ST_CN_1;
                end
            end

            // Connect: copy end vertices, then two splices.
            qete_pkg::ST_CN_1:
            begin
                vs_raddr   = qete_pkg::edge_turn(a_reg, 2'd2);
                state_next = qete_pkg::ST_CN_2;
            end
            qete_pkg::ST_CN_2:
            begin
                vs_raddr   = b_reg;
                xv_next    = vs_q;
                state_next = qete_pkg::ST_CN_3;
            end
            qete_pkg::ST_CN_3:
            begin
                yv_next    = vs_q;
                vs_we      = 1'b1;
                vs_waddr   = e_reg;
                vs_wdata   = xv_reg;
                ring_raddr = qete_pkg::edge_turn(a_reg, 2'd3);
                state_next = qete_pkg::ST_CN_4;
            end
            qete_pkg::ST_CN_4:
            begin
                vs_we      = 1'b1;
                vs_waddr   = qete_pkg::edge_turn(e_reg, 2'd2);
                vs_wdata   = yv_reg;
                sa_next    = e_reg;
                sb_next    = qete_pkg::edge_turn(ring_q, 2'd1);
                ret_next   = qete_pkg::ST_CN_5;
                state_next = qete_pkg::ST_SP_RA;
            end
            qete_pkg::ST_CN_5:
            begin
                sa_next    = qete_pkg::edge_turn(e_reg, 2'd2);
                sb_next    = b_reg;
                ret_next   = qete_pkg::ST_OUT_R;
                state_next = qete_pkg::ST_SP_RA;
            end

            // Delete: detach both ends, then push the quad.
            qete_pkg::ST_DL_1:
            begin
                ring_raddr = qete_pkg::edge_turn(a_reg, 2'd1);
                state_next = qete_pkg::ST_DL_2;
            end
            qete_pkg::ST_DL_2:
            begin
                sa_next    = a_reg;
                sb_next    = qete_pkg::edge_turn(ring_q, 2'd1);
                ret_next   = qete_pkg::ST_DL_3;
                state_next = qete_pkg::ST_SP_RA;
            end
            qete_pkg::ST_DL_3:
            begin
                ring_raddr = qete_pkg::edge_turn(a_reg, 2'd3);
                state_next = qete_pkg::ST_DL_4;
            end
            qete_pkg::ST_DL_4:
            begin
                sa_next    = qete_pkg::edge_turn(a_reg, 2'd2);
                sb_next    = qete_pkg::edge_turn(ring_q, 2'd1);
                ret_next   = qete_pkg::ST_DL_5;
                state_next = qete_pkg::ST_SP_RA;
            end
            qete_pkg::ST_DL_5:
            begin
                // A push onto a full stack is dropped.
                if (!free_top_reg[qete_pkg::QuadBits])
                begin
                    fs_we         = 1'b1;
                    free_top_next = free_top_reg + 1'b1;
                end
                state_next = qete_pkg::ST_OUT_R;
            end

            // Swap: rotate the edge inside its enclosing quadrilateral.
            qete_pkg::ST_SW_1:
            begin
                ring_raddr = qete_pkg::edge_turn(a_reg, 2'd1);
                state_next = qete_pkg::ST_SW_2;
            end
            qete_pkg::ST_SW_2:
            begin
                ring_raddr = qete_pkg::edge_turn(a_reg, 2'd3);
                x_next     = qete_pkg::edge_turn(ring_q, 2'd1);
                state_next = qete_pkg::ST_SW_3;
            end
            qete_pkg::ST_SW_3:
            begin
                y_next     = qete_pkg::edge_turn(ring_q, 2'd1);
                sa_next    = a_reg;
                sb_next    = x_reg;
                ret_next   = qete_pkg::ST_SW_4;
                state_next = qete_pkg::ST_SP_RA;
            end
            qete_pkg::ST_SW_4:
            begin
                sa_next    = qete_pkg::edge_turn(a_reg, 2'd2);
                sb_next    = y_reg;
                ret_next   = qete_pkg::ST_SW_5;
                state_next = qete_pkg::ST_SP_RA;
            end
            qete_pkg::ST_SW_5:
            begin
                ring_raddr = qete_pkg::edge_turn(x_reg, 2'd3);
                state_next = qete_pkg::ST_SW_6;
            end
            qete_pkg::ST_SW_6:
            begin
                sa_next    = a_reg;
                sb_next    = qete_pkg::edge_turn(ring_q, 2'd1);
                ret_next   = qete_pkg::ST_SW_7;
                state_next = qete_pkg::ST_SP_RA;
            end
            qete_pkg::ST_SW_7:
            begin
                ring_raddr = qete_pkg::edge_turn(y_reg, 2'd3);
                state_next = qete_pkg::ST_SW_8;
            end
            qete_pkg::ST_SW_8:
            begin
                sa_next    = qete_pkg::edge_turn(a_reg, 2'd2);
                sb_next    = qete_pkg::edge_turn(ring_q, 2'd1);
                ret_next   = qete_pkg::ST_SW_9;
                state_next = qete_pkg::ST_SP_RA;
            end
            qete_pkg::ST_SW_9:
            begin
                vs_raddr   = qete_pkg::edge_turn(x_reg, 2'd2);
                state_next = qete_pkg::ST_SW_10;
            end
            qete_pkg::ST_SW_10:
            begin
                vs_we      = 1'b1;
                vs_waddr   = a_reg;
                vs_wdata   = vs_q;
                state_next = qete_pkg::ST_SW_11;
            end
            qete_pkg::ST_SW_11:
            begin
                vs_raddr   = qete_pkg::edge_turn(y_reg, 2'd2);
                state_next = qete_pkg::ST_SW_12;
            end
            qete_pkg::ST_SW_12:
            begin
                vs_we      = 1'b1;
                vs_waddr   = qete_pkg::edge_turn(a_reg, 2'd2);
                vs_wdata   = vs_q;
                state_next = qete_pkg::ST_OUT_R;
            end

            // Splice subroutine on sa and sb; returns to ret_reg.
            qete_pkg::ST_SP_RA:
            begin
                ring_raddr = sa_reg;
                state_next = qete_pkg::ST_SP_RB;
            end
            qete_pkg::ST_SP_RB:
            begin
                ring_raddr = sb_reg;
                ta_next    = ring_q;
                state_next = qete_pkg::ST_SP_WA;
            end
            qete_pkg::ST_SP_WA:
            begin
                tb_next    = ring_q;
                ring_we    = 1'b1;
                ring_waddr = sa_reg;
                ring_wdata = ring_q;
                state_next = qete_pkg::ST_SP_WB;
            end
            qete_pkg::ST_SP_WB:
            begin
                ring_we    = 1'b1;
                ring_waddr = sb_reg;
                ring_wdata = ta_reg;
                state_next = qete_pkg::ST_SP_RAL;
            end
            qete_pkg::ST_SP_RAL:
            begin
                ring_raddr = qete_pkg::edge_turn(ta_reg, 2'd1);
                state_next = qete_pkg::ST_SP_RBE;
            end
            qete_pkg::ST_SP_RBE:
            begin
                ring_raddr = qete_pkg::edge_turn(tb_reg, 2'd1);
                u_next     = ring_q;
                state_next = qete_pkg::ST_SP_WAL;
            end
            qete_pkg::ST_SP_WAL:
            begin
                ring_we    = 1'b1;
                ring_waddr = qete_pkg::edge_turn(ta_reg, 2'd1);
                ring_wdata = ring_q;
                state_next = qete_pkg::ST_SP_WBE;
            end
            qete_pkg::ST_SP_WBE:
            begin
                ring_we    = 1'b1;
                ring_waddr = qete_pkg::edge_turn(tb_reg, 2'd1);
                ring_wdata = u_reg;
                state_next = ret_reg;
            end

            // Result readout.
            qete_pkg::ST_OUT_R:
            begin
                ring_raddr = r_sel;
                vs_raddr   = r_sel;
                state_next = qete_pkg::ST_OUT_S;
            end
            qete_pkg::ST_OUT_S:
            begin
                on_next    = ring_q;
                ori_next   = vs_q;
                vs_raddr   = qete_pkg::edge_turn(r_sel, 2'd2);
                state_next = qete_pkg::ST_OUT_D;
            end
            qete_pkg::ST_OUT_D:
            begin
                // Keep the destination record on the read port while waiting.
                vs_raddr = qete_pkg::edge_turn(r_sel, 2'd2);
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = err_reg;
                    res_next       = err_reg ? '0 : r_sel;
                    onx_out_next   = err_reg ? '0 : on_reg;
                    org_out_next   = err_reg ? '0 : ori_reg;
                    dst_out_next   = err_reg ? '0 : vs_q;
                    state_next     = qete_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qete_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign result_edge = res_reg;
    assign onext_edge  = onx_out_reg;
    assign origin_id   = org_out_reg;
    assign dest_id     = dst_out_reg;
    assign status      = status_reg;

endmodule

[hw/rtl/qete_checker.sv]
// ----------------------------------------------------------------------------
// Quad-edge topology engine port checker
// Watches the top-level ports and flags request and result ordering slips.
// ----------------------------------------------------------------------------
module qete_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [9:0]  result_edge,
    input logic [9:0]  onext_edge,
    input logic [15:0] origin_id,
    input logic [15:0] dest_id,
    input logic        status
);

    // A stalled result keeps its edge fields and its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_edge)
            && $stable(onext_edge) && $stable(status))
        else $error("stalled result changed");

    // An exhausted pool reports only the status flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> result_edge == '0 && onext_edge == '0
            && origin_id == '0 && dest_id == '0)
        else $error("error result carries data");

    // The engine is busy right after taking a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // No result can appear in the cycle after a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");

endmodule

bind quad_edge_topology_engine_unit qete_checker u_qete_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_edge (result_edge),
    .onext_edge  (onext_edge),
    .origin_id   (origin_id),
    .dest_id     (dest_id),
    .status      (status)
);

[tb/quad_edge_topology_engine_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quad-edge topology engine testbench
// A directed table is followed by random request streams over several idle
// and stall phases. Every result is checked against a local model of the
// quad-edge pool that is updated as each request is accepted.
// ----------------------------------------------------------------------------
module quad_edge_topology_engine_unit_tb;

    // Opcodes above query are decoded as query by the block.
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int PEND_DEPTH  = 8;

    typedef struct packed {
        logic [2:0]        op;
        qete_pkg::edge_t   ea;
        qete_pkg::edge_t   eb;
        qete_pkg::vertex_t org;
        qete_pkg::vertex_t dst;
    } request_t;

    typedef struct packed {
        qete_pkg::edge_t   edge_id;
        qete_pkg::edge_t   onext;
        qete_pkg::vertex_t origin;
        qete_pkg::vertex_t dest;
        logic              exhausted;
    } answer_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        answer_t  ans;
    } table_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        opcode;
    qete_pkg::edge_t   edge_a;
    qete_pkg::edge_t   edge_b;
    qete_pkg::vertex_t org_vertex;
    qete_pkg::vertex_t dst_vertex;
    logic              out_valid;
    logic              out_ready;
    qete_pkg::edge_t   result_edge;
    qete_pkg::edge_t   onext_edge;
    qete_pkg::vertex_t origin_id;
    qete_pkg::vertex_t dest_id;
    logic              status;

    quad_edge_topology_engine_unit DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .edge_a      (edge_a),
        .edge_b      (edge_b),
        .org_vertex  (org_vertex),
        .dst_vertex  (dst_vertex),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_edge (result_edge),
        .onext_edge  (onext_edge),
        .origin_id   (origin_id),
        .dest_id     (dest_id),
        .status      (status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Local copy of the quad-edge pool. The ring holds each record's onext,
    // the vertex array each record's vertex id. Freed quads are pushed onto
    // a stack and reused before any fresh quad is taken.
    // ------------------------------------------------------------------------
    qete_pkg::edge_t   ring_mem[1024];
    qete_pkg::vertex_t vert_mem[1024];
    logic [7:0]        free_quads[256];
    int                free_count  = 0;
    int                fresh_count = 0;

    // Expected answers in request order; the sender fills, the checker drains.
    answer_t pend_fifo[PEND_DEPTH];
    int      pend_wr         = 0;
    int      pend_rd         = 0;
    int      error_count     = 0;
    int      results_seen    = 0;
    int      exhausted_seen  = 0;
    int      requests_sent   = 0;
    int      op_histogram[8];
    int      sender_idle_pct = 0;
    int      recv_stall_pct  = 0;
    bit      hold_request    = 1'b0;

    // Quarter-turn an edge reference within its quad.
    function automatic qete_pkg::edge_t turn_edge(input qete_pkg::edge_t e, input int k);
        return {e[9:2], 2'(e[1:0] + 2'(k))};
    endfunction

    function automatic qete_pkg::edge_t prev_around_origin(input qete_pkg::edge_t e);
        return turn_edge(ring_mem[turn_edge(e, 1)], 1);
    endfunction

    function automatic qete_pkg::edge_t next_around_left(input qete_pkg::edge_t e);
        return turn_edge(ring_mem[turn_edge(e, 3)], 1);
    endfunction

    // Splice swaps the origin rings of a and b and the dual rings of their
    // left faces.
    function automatic void splice_rings(input qete_pkg::edge_t a, input qete_pkg::edge_t b);
        qete_pkg::edge_t al;
        qete_pkg::edge_t be;
        qete_pkg::edge_t t1;
        qete_pkg::edge_t t2;
        al = turn_edge(ring_mem[a], 1);
        be = turn_edge(ring_mem[b], 1);
        t1 = ring_mem[a];
        t2 = ring_mem[b];
        ring_mem[a] = t2;
        ring_mem[b] = t1;
        t1 = ring_mem[al];
        t2 = ring_mem[be];
        ring_mem[al] = t2;
        ring_mem[be] = t1;
    endfunction

    // Take a quad and build an isolated edge in it. Returns 0 if the pool
    // is exhausted.
    function automatic bit grab_quad(output qete_pkg::edge_t e);
        qete_pkg::edge_t base;
        if (free_count > 0)
        begin
            free_count--;
            base = {free_quads[free_count], 2'd0};
        end
        else if (fresh_count < qete_pkg::QuadEdges)
        begin
            base = {8'(fresh_count), 2'd0};
            fresh_count++;
        end
        else
        begin
            e = '0;
            return 1'b0;
        end
        ring_mem[base]               = base;
        ring_mem[turn_edge(base, 1)] = turn_edge(base, 3);
        ring_mem[turn_edge(base, 2)] = turn_edge(base, 2);
        ring_mem[turn_edge(base, 3)] = turn_edge(base, 1);
        vert_mem[turn_edge(base, 1)] = '0;
        vert_mem[turn_edge(base, 3)] = '0;
        e = base;
        return 1'b1;
    endfunction

    // Apply one request to the local pool and return the result it causes.
    function automatic answer_t apply_request(input request_t rq);
        answer_t           ans;
        qete_pkg::edge_t   r;
        qete_pkg::edge_t   e;
        qete_pkg::edge_t   x;
        qete_pkg::edge_t   y;
        qete_pkg::vertex_t vx;
        qete_pkg::vertex_t vy;
        r = rq.ea;
        case (rq.op)
            qete_pkg::OP_MAKE, qete_pkg::OP_CONNECT:
            begin
                if (!grab_quad(e))
                begin
                    ans = '0;
                    ans.exhausted = 1'b1;
                    return ans;
                end
                if (rq.op == qete_pkg::OP_MAKE)
                begin
                    vert_mem[e] = rq.org;
                    vert_mem[turn_edge(e, 2)] = rq.dst;
                end
                else
                begin
                    vx = vert_mem[turn_edge(rq.ea, 2)];
                    vy = vert_mem[rq.eb];
                    vert_mem[e] = vx;
                    vert_mem[turn_edge(e, 2)] = vy;
                    splice_rings(e, next_around_left(rq.ea));
                    splice_rings(turn_edge(e, 2), rq.eb);
                end
                r = e;
            end
            qete_pkg::OP_SPLICE:
                splice_rings(rq.ea, rq.eb);
            qete_pkg::OP_DELETE:
            begin
                splice_rings(rq.ea, prev_around_origin(rq.ea));
                splice_rings(turn_edge(rq.ea, 2), prev_around_origin(turn_edge(rq.ea, 2)));
                // A full stack silently drops the push.
                if (free_count < qete_pkg::QuadEdges)
                begin
                    free_quads[free_count] = rq.ea[9:2];
                    free_count++;
                end
            end
            qete_pkg::OP_SWAP:
            begin
                x = prev_around_origin(rq.ea);
                y = prev_around_origin(turn_edge(rq.ea, 2));
                splice_rings(rq.ea, x);
                splice_rings(turn_edge(rq.ea, 2), y);
                splice_rings(rq.ea, next_around_left(x));
                splice_rings(turn_edge(rq.ea, 2), next_around_left(y));
                vert_mem[rq.ea] = vert_mem[turn_edge(x, 2)];
                vert_mem[turn_edge(rq.ea, 2)] = vert_mem[turn_edge(y, 2)];
            end
            default:
            begin
            end
        endcase
        ans.edge_id   = r;
        ans.onext     = ring_mem[r];
        ans.origin    = vert_mem[r];
        ans.dest      = vert_mem[turn_edge(r, 2)];
        ans.exhausted = 1'b0;
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. The payload is set with valid and held until accepted;
    // the model is updated right at the accepting edge so that the next
    // random request sees the current pool.
    // ------------------------------------------------------------------------
    task automatic send_request(input request_t rq, input logic typed, input answer_t typed_ans);
        answer_t ans;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        opcode     <= rq.op;
        edge_a     <= rq.ea;
        edge_b     <= rq.eb;
        org_vertex <= rq.org;
        dst_vertex <= rq.dst;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        ans = apply_request(rq);
        pend_fifo[pend_wr % PEND_DEPTH] = typed ? typed_ans : ans;
        pend_wr++;
        op_histogram[rq.op]++;
        requests_sent++;
    endtask

    // Pick a vertex id, favoring the extremes now and then.
    function automatic qete_pkg::vertex_t pick_vertex();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return qete_pkg::vertex_t'($urandom);
        endcase
    endfunction

    // Only edges of quads that were allocated at some point are referenced,
    // so no record that was never written is ever read.
    function automatic qete_pkg::edge_t pick_live_edge();
        return {8'($urandom_range(fresh_count - 1)), 2'($urandom_range(3))};
    endfunction

    function automatic request_t random_request();
        request_t rq;
        int       roll;
        rq.ea  = qete_pkg::edge_t'($urandom);
        rq.eb  = qete_pkg::edge_t'($urandom);
        rq.org = pick_vertex();
        rq.dst = pick_vertex();
        roll = (fresh_count == 0) ? 0 : $urandom_range(99);
        if (roll < 38)
            rq.op = qete_pkg::OP_MAKE;
        else if (roll < 50)
            rq.op = qete_pkg::OP_CONNECT;
        else if (roll < 62)
            rq.op = qete_pkg::OP_SPLICE;
        else if (roll < 70)
            rq.op = qete_pkg::OP_DELETE;
        else if (roll < 80)
            rq.op = qete_pkg::OP_SWAP;
        else if (roll < 92)
            rq.op = qete_pkg::OP_QUERY;
        else if (roll < 96)
            rq.op = OP_SPARE6;
        else
            rq.op = OP_SPARE7;
        if (rq.op != qete_pkg::OP_MAKE)
            rq.ea = pick_live_edge();
        if (rq.op == qete_pkg::OP_SPLICE || rq.op == qete_pkg::OP_CONNECT)
            rq.eb = pick_live_edge();
        return rq;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every accepted result is matched against the oldest
    // pending answer, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        answer_t exp_ans;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pend_wr == pend_rd)
            begin
                $error("result with no request pending: edge %0d", result_edge);
                error_count++;
            end
            else
            begin
                exp_ans = pend_fifo[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (exp_ans.exhausted)
                    exhausted_seen++;
                if (result_edge !== exp_ans.edge_id)
                begin
                    $error("result_edge expected %0d got %0d", exp_ans.edge_id, result_edge);
                    error_count++;
                end
                if (onext_edge !== exp_ans.onext)
                begin
                    $error("onext_edge expected %0d got %0d", exp_ans.onext, onext_edge);
                    error_count++;
                end
                if (origin_id !== exp_ans.origin)
                begin
                    $error("origin_id expected %0h got %0h", exp_ans.origin, origin_id);
                    error_count++;
                end
                if (dest_id !== exp_ans.dest)
                begin
                    $error("dest_id expected %0h got %0h", exp_ans.dest, dest_id);
                    error_count++;
                end
                if (status !== exp_ans.exhausted)
                begin
                    $error("status expected %0b got %0b", exp_ans.exhausted, status);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Stalls at the phase's rate; on request it also holds off for
    // a long stretch so the block fills up and pushes back on its input.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        int hold_left;
        bit hold_taken;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_request && !hold_taken)
            begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too many cycles with no request moving on either side.
    always @(posedge clk)
    begin
        int quiet_cycles;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: %0d requests still pending", pend_wr - pend_rd);
            $display("quad_edge_topology_engine_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed table. Rows with typed answers are read straight off the
    // definition: fresh isolated edges and their duals after reset. The rest
    // exercise splice, connect, swap, delete, edge reuse from the free stack,
    // the spare opcodes and deleting an edge that is already dead.
    // ------------------------------------------------------------------------
    table_row_t directed_rows[14];

    initial
    begin
        int      phase_idx;
        int      n;
        int      wait_cycles;
        answer_t no_ans;

        directed_rows[0]  = '{'{qete_pkg::OP_MAKE, 10'd1023, 10'd1023, 16'h0000, 16'hFFFF},
                              1'b1, '{10'd0, 10'd0, 16'h0000, 16'hFFFF, 1'b0}};
        directed_rows[1]  = '{'{qete_pkg::OP_MAKE, 10'd0, 10'd0, 16'hFFFF, 16'h0000}, 1'b1,
                              '{10'd4, 10'd4, 16'hFFFF, 16'h0000, 1'b0}};
        directed_rows[2]  = '{'{qete_pkg::OP_QUERY, 10'd0, 10'd1023, 16'h0000, 16'h0000},
                              1'b1, '{10'd0, 10'd0, 16'h0000, 16'hFFFF, 1'b0}};
        directed_rows[3]  = '{'{qete_pkg::OP_QUERY, 10'd1, 10'd0, 16'hFFFF, 16'hFFFF}, 1'b1,
                              '{10'd1, 10'd3, 16'h0000, 16'h0000, 1'b0}};
        directed_rows[4]  = '{'{qete_pkg::OP_SPLICE, 10'd0, 10'd4, 16'h1234, 16'h5678},
                              1'b0, '0};
        directed_rows[5]  = '{'{qete_pkg::OP_CONNECT, 10'd2, 10'd4, 16'h0000, 16'h0000},
                              1'b0, '0};
        directed_rows[6]  = '{'{qete_pkg::OP_MAKE, 10'd0, 10'd0, 16'hA5A5, 16'h5A5A}, 1'b0, '0};
        directed_rows[7]  = '{'{qete_pkg::OP_SWAP, 10'd8, 10'd1023, 16'h0000, 16'h0000},
                              1'b0, '0};
        directed_rows[8]  = '{'{qete_pkg::OP_DELETE, 10'd8, 10'd0, 16'h0000, 16'h0000},
                              1'b0, '0};
        directed_rows[9]  = '{'{qete_pkg::OP_MAKE, 10'd0, 10'd0, 16'h0001, 16'h8000}, 1'b0, '0};
        directed_rows[10] = '{'{OP_SPARE6, 10'd4, 10'd0, 16'h0000, 16'h0000}, 1'b0, '0};
        directed_rows[11] = '{'{OP_SPARE7, 10'd5, 10'd0, 16'h0000, 16'h0000}, 1'b0, '0};
        directed_rows[12] = '{'{qete_pkg::OP_DELETE, 10'd14, 10'd0, 16'h0000, 16'h0000},
                              1'b0, '0};
        directed_rows[13] = '{'{qete_pkg::OP_DELETE, 10'd14, 10'd0, 16'h0000, 16'h0000},
                              1'b0, '0};

        foreach (op_histogram[i])
            op_histogram[i] = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = qete_pkg::OP_QUERY;
        edge_a     = '0;
        edge_b     = '0;
        org_vertex = '0;
        dst_vertex = '0;
        no_ans     = '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].ans);

        // Random phases: no idling (with a long receiver hold-off at its
        // start), a slow sender, a slow receiver, then both idling.
        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            case (phase_idx)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  hold_request = 1'b1; end
                1: begin sender_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin sender_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (n = 0; n < 210; n++)
                send_request(random_request(), 1'b0, no_ans);
        end
        in_valid <= 1'b0;

        // Drain, then allow the longest operation to settle.
        while (pend_wr != pend_rd)
            @(posedge clk);
        for (wait_cycles = 0; wait_cycles < 60; wait_cycles++)
            @(posedge clk);

        $display("covered %0d requests (make %0d, splice %0d, connect %0d, delete %0d, swap %0d)",
                 requests_sent, op_histogram[qete_pkg::OP_MAKE],
                 op_histogram[qete_pkg::OP_SPLICE], op_histogram[qete_pkg::OP_CONNECT],
                 op_histogram[qete_pkg::OP_DELETE], op_histogram[qete_pkg::OP_SWAP]);
        $display("%0d results checked, %0d with the pool exhausted, %0d quads ever used",
                 results_seen, exhausted_seen, fresh_count);
        if (error_count == 0)
            $display("quad_edge_topology_engine_unit test passed");
        else
            $display("quad_edge_topology_engine_unit test failed");
        $finish;
    end

endmodule
